[rtl/core/ratio_with_error_propagation_macros.svh]
// Assertion helpers for the checker of the ratio block.
`ifndef RATIO_WITH_ERROR_PROPAGATION_MACROS_SVH
`define RATIO_WITH_ERROR_PROPAGATION_MACROS_SVH

// Same-cycle implication, masked while reset is active.
`define RWEP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rwep checker: same-cycle property failed");

// Next-cycle implication, masked while reset is active.
`define RWEP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rwep checker: next-cycle property failed");

// Same-cycle implication that is also checked during reset.
`define RWEP_ASSERT_ALWAYS(lbl, clk, ante, cons) \
	lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
		else $error("rwep checker: reset property failed");

`endif

[rtl/core/rwep_pkg.sv]
`default_nettype none
package rwep_pkg;

	localparam int DEF_FRAC_BITS   = 16;
	localparam int DEF_VALUE_WIDTH = 32;
	// quotient terms are clipped to at most this many bits
	localparam int TERM_CAP_BITS   = 62;
	localparam int DIV_LANES       = 5;

endpackage
`default_nettype wire

[rtl/core/rwep_in_if.sv]
`default_nettype none
interface rwep_in_if
	import rwep_pkg::*;
#(
	parameter int W = DEF_VALUE_WIDTH
) ();
	logic         valid;
	logic         ready;
	logic [W-1:0] x_value;
	logic [W-1:0] num_value;
	logic [W-1:0] den_value;
	logic [W-2:0] num_err_up;
	logic [W-2:0] num_err_down;
	logic [W-2:0] den_err_up;
	logic [W-2:0] den_err_down;
	logic [W-2:0] num_xerr_high;
	logic [W-2:0] num_xerr_low;
	logic [W-2:0] den_xerr_high;
	logic [W-2:0] den_xerr_low;

	modport source (output valid, x_value, num_value, den_value, num_err_up, num_err_down,
		den_err_up, den_err_down, num_xerr_high, num_xerr_low, den_xerr_high, den_xerr_low,
		input ready);
	modport sink (input valid, x_value, num_value, den_value, num_err_up, num_err_down,
		den_err_up, den_err_down, num_xerr_high, num_xerr_low, den_xerr_high, den_xerr_low,
		output ready);
endinterface
`default_nettype wire

[rtl/core/rwep_out_if.sv]
`default_nettype none
interface rwep_out_if
	import rwep_pkg::*;
#(
	parameter int W = DEF_VALUE_WIDTH
) ();
	logic         valid;
	logic         ready;
	logic [W-1:0] x_out;
	logic [W-1:0] ratio;
	logic [W-2:0] ratio_err_up;
	logic [W-2:0] ratio_err_down;
	logic [W-2:0] xerr_high_out;
	logic [W-2:0] xerr_low_out;
	logic         saturated;

	modport source (output valid, x_out, ratio, ratio_err_up, ratio_err_down, xerr_high_out,
		xerr_low_out, saturated, input ready);
	modport sink (input valid, x_out, ratio, ratio_err_up, ratio_err_down, xerr_high_out,
		xerr_low_out, saturated, output ready);
endinterface
`default_nettype wire

[rtl/core/rwep_div_cell.sv]
`default_nettype none
// One restoring division step: shift in one dividend bit, subtract if it fits.
module rwep_div_cell #(
	parameter int W  = 32,
	parameter int QW = 48,
	parameter int J  = 0
) (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic [W-1:0]  rem_i,
	input  wire logic [QW-1:0] quo_i,
	input  wire logic [W-1:0]  a_i,
	input  wire logic [W-1:0]  d_i,
	output logic      [W-1:0]  rem_o,
	output logic      [QW-1:0] quo_o,
	output logic      [W-1:0]  a_o,
	output logic      [W-1:0]  d_o
);
	logic         bit_in;
	logic [W:0]   cur;
	logic [W:0]   diff;
	logic         ge;

	generate
		if (J < W) begin : g_data
			assign bit_in = a_i[W-1-J];
		end else begin : g_zero
			assign bit_in = 1'b0;
		end
	endgenerate

	assign cur  = {rem_i, bit_in};
	assign diff = cur - {1'b0, d_i};
	assign ge   = (cur >= {1'b0, d_i});

	always_ff @(posedge clk) begin
		if (en) begin
			rem_o <= ge ? diff[W-1:0] : cur[W-1:0];
			quo_o <= {quo_i[QW-2:0], ge};
			a_o   <= a_i;
			d_o   <= d_i;
		end
	end
endmodule
`default_nettype wire

[rtl/core/rwep_sqrt_cell.sv]
`default_nettype none
// One digit-by-digit square root step: bring down two radicand bits, try root*4+1.
module rwep_sqrt_cell #(
	parameter int RW = 48,
	parameter int I  = 0
) (
	input  wire logic            clk,
	input  wire logic            en,
	input  wire logic [2*RW-1:0] n_i,
	input  wire logic [RW+1:0]   rem_i,
	input  wire logic [RW-1:0]   root_i,
	output logic      [2*RW-1:0] n_o,
	output logic      [RW+1:0]   rem_o,
	output logic      [RW-1:0]   root_o
);
	logic [RW+3:0] cur;
	logic [RW+3:0] trial;
	logic [RW+3:0] diff;
	logic          ge;

	assign cur   = {rem_i, n_i[2*RW-1-2*I -: 2]};
	assign trial = {2'b00, root_i, 2'b01};
	assign diff  = cur - trial;
	assign ge    = (cur >= trial);

	always_ff @(posedge clk) begin
		if (en) begin
			n_o    <= n_i;
			rem_o  <= ge ? diff[RW+1:0] : cur[RW+1:0];
			root_o <= {root_i[RW-2:0], ge};
		end
	end
endmodule
`default_nettype wire

[rtl/core/rwep_mul.sv]
`default_nettype none
// Two-stage unsigned multiplier: four half-width partial products, then their sum.
module rwep_mul #(
	parameter int AW = 47,
	parameter int BW = 47
) (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic [AW-1:0]    a,
	input  wire logic [BW-1:0]    b,
	output logic      [AW+BW-1:0] p
);
	localparam int AH = (AW + 1) / 2;
	localparam int AU = AW - AH;
	localparam int BH = (BW + 1) / 2;
	localparam int BU = BW - BH;
	localparam int PW = AW + BW;

	logic [AH+BH-1:0] p00_s1;
	logic [AH+BU-1:0] p01_s1;
	logic [AU+BH-1:0] p10_s1;
	logic [AU+BU-1:0] p11_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			p00_s1 <= (AH+BH)'(a[AH-1:0])  * (AH+BH)'(b[BH-1:0]);
			p01_s1 <= (AH+BU)'(a[AH-1:0])  * (AH+BU)'(b[BW-1:BH]);
			p10_s1 <= (AU+BH)'(a[AW-1:AH]) * (AU+BH)'(b[BH-1:0]);
			p11_s1 <= (AU+BU)'(a[AW-1:AH]) * (AU+BU)'(b[BW-1:BH]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p <= (PW'(p11_s1) << (AH + BH)) + (PW'(p10_s1) << AH)
				+ (PW'(p01_s1) << BH) + PW'(p00_s1);
		end
	end
endmodule
`default_nettype wire

[rtl/core/ratio_with_error_propagation.sv]
// Throughput: one item per cycle; every divider and root step is its own cell stage.
// The whole pipe stalls together only while a finished result is not taken.
// Reset (arst_n low, asynchronous) empties the pipe; data registers are not reset.
`default_nettype none
module ratio_with_error_propagation
	import rwep_pkg::*;
#(
	parameter int FRAC_BITS   = DEF_FRAC_BITS,
	parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
	input  wire logic clk,
	input  wire logic arst_n,
	rwep_in_if.sink   point,
	rwep_out_if.source result
);
	localparam int W   = VALUE_WIDTH;
	localparam int F   = FRAC_BITS;
	localparam int EW  = W - 1;
	localparam int QW  = W + F;
	localparam int TW  = (EW + F > TERM_CAP_BITS) ? TERM_CAP_BITS : EW + F;
	localparam int RW  = TW + 1;
	localparam int SW  = 2 * RW;
	localparam int PW  = RW + W;
	localparam int NST = QW + RW + 8;
	localparam int PL  = RW + 6;

	localparam logic [W-1:0]  ONE_Q   = W'(1) << F;
	localparam logic [QW-1:0] POS_LIM = (QW'(1) << EW) - QW'(1);
	localparam logic [QW-1:0] NEG_LIM = QW'(1) << EW;

	typedef struct packed {
		logic [W-1:0]  x;
		logic [EW-1:0] xh;
		logic [EW-1:0] xl;
		logic          nneg;
		logic          dpos;
	} pre_t;

	typedef struct packed {
		logic [W-1:0]  x;
		logic [EW-1:0] xh;
		logic [EW-1:0] xl;
		logic [W-1:0]  ratio;
		logic [W-1:0]  rp;
		logic          sat;
	} post_t;

	// global advance: the pipe moves whenever the output slot is free or being taken
	logic           en;
	logic           in_acc;
	logic [NST-1:0] vld_q;

	assign en          = !vld_q[NST-1] || result.ready;
	assign point.ready = en;
	assign in_acc      = point.valid && en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NST-2:0], in_acc};
		end
	end

	// ---- input stage: magnitudes, zero substitutes, divider operands ----
	logic         nneg, dneg, dpos;
	logic [W-1:0] nmag, dmag, nd, dd;
	logic [W-1:0] a_s1 [DIV_LANES];
	logic [W-1:0] d_s1 [DIV_LANES];
	pre_t         pre_s1;

	assign nneg = point.num_value[W-1];
	assign dneg = point.den_value[W-1];
	assign nmag = nneg ? (~point.num_value + W'(1)) : point.num_value;
	assign dmag = dneg ? (~point.den_value + W'(1)) : point.den_value;
	assign dpos = !dneg && (dmag != '0);
	assign nd   = (nmag != '0) ? nmag : ONE_Q;
	assign dd   = (dmag != '0) ? dmag : ONE_Q;

	always_ff @(posedge clk) begin
		if (en) begin
			// lane 0 ratio, 1 up/num, 2 up/den, 3 down/num, 4 down/den
			a_s1[0] <= nmag;
			d_s1[0] <= dd;
			a_s1[1] <= {1'b0, point.num_err_up};
			d_s1[1] <= nd;
			a_s1[2] <= {1'b0, point.den_err_down};
			d_s1[2] <= dd;
			a_s1[3] <= {1'b0, point.num_err_down};
			d_s1[3] <= nd;
			a_s1[4] <= {1'b0, point.den_err_up};
			d_s1[4] <= dd;
			pre_s1.x    <= point.x_value;
			pre_s1.xh   <= (point.num_xerr_high > point.den_xerr_high) ?
				point.num_xerr_high : point.den_xerr_high;
			pre_s1.xl   <= (point.num_xerr_low > point.den_xerr_low) ?
				point.num_xerr_low : point.den_xerr_low;
			pre_s1.nneg <= nneg;
			pre_s1.dpos <= dpos;
		end
	end

	// ---- five divider chains, one quotient bit per cell ----
	logic [W-1:0]  drem [DIV_LANES][QW+1];
	logic [QW-1:0] dquo [DIV_LANES][QW+1];
	logic [W-1:0]  da   [DIV_LANES][QW+1];
	logic [W-1:0]  ddv  [DIV_LANES][QW+1];

	generate
		for (genvar l = 0; l < DIV_LANES; l++) begin : g_lane
			assign drem[l][0] = '0;
			assign dquo[l][0] = '0;
			assign da[l][0]   = a_s1[l];
			assign ddv[l][0]  = d_s1[l];
			for (genvar k = 0; k < QW; k++) begin : g_cell
				rwep_div_cell #(.W(W), .QW(QW), .J(k)) u_cell (
					.clk   (clk),
					.en    (en),
					.rem_i (drem[l][k]),
					.quo_i (dquo[l][k]),
					.a_i   (da[l][k]),
					.d_i   (ddv[l][k]),
					.rem_o (drem[l][k+1]),
					.quo_o (dquo[l][k+1]),
					.a_o   (da[l][k+1]),
					.d_o   (ddv[l][k+1])
				);
			end
		end
	endgenerate

	// side data rides alongside the divider cells
	pre_t pre_q [QW];

	always_ff @(posedge clk) begin
		if (en) begin
			pre_q[0] <= pre_s1;
			for (int k = 1; k < QW; k++) begin
				pre_q[k] <= pre_q[k-1];
			end
		end
	end

	// ---- clip stage: signed ratio with saturation, error terms clipped ----
	pre_t          pre_end;
	logic [QW-1:0] q0, lim;
	logic          rsat;
	logic [W-1:0]  qmag, rat;
	logic [3:0]    tsat;
	logic [TW-1:0] tclip [4];
	logic [TW-1:0] t_s2  [4];
	post_t         post_q [PL];

	assign pre_end = pre_q[QW-1];
	assign q0      = dquo[0][QW];
	assign lim     = pre_end.nneg ? NEG_LIM : POS_LIM;
	assign rsat    = pre_end.dpos && (q0 > lim);
	assign qmag    = !pre_end.dpos ? '0 : (rsat ? lim[W-1:0] : q0[W-1:0]);
	assign rat     = pre_end.nneg ? (~qmag + W'(1)) : qmag;

	always_comb begin
		for (int t = 0; t < 4; t++) begin
			tsat[t]  = |dquo[t+1][QW][QW-1:TW];
			tclip[t] = tsat[t] ? '1 : dquo[t+1][QW][TW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int t = 0; t < 4; t++) begin
				t_s2[t] <= tclip[t];
			end
			post_q[0].x     <= pre_end.x;
			post_q[0].xh    <= pre_end.xh;
			post_q[0].xl    <= pre_end.xl;
			post_q[0].ratio <= rat;
			post_q[0].rp    <= (qmag != '0) ? qmag : ONE_Q;
			post_q[0].sat   <= rsat || (|tsat);
			for (int k = 1; k < PL; k++) begin
				post_q[k] <= post_q[k-1];
			end
		end
	end

	// ---- squares of the four terms ----
	logic [2*TW-1:0] sq [4];

	generate
		for (genvar t = 0; t < 4; t++) begin : g_sq
			rwep_mul #(.AW(TW), .BW(TW)) u_sq (
				.clk (clk),
				.en  (en),
				.a   (t_s2[t]),
				.b   (t_s2[t]),
				.p   (sq[t])
			);
		end
	endgenerate

	// ---- sum of squares, then two root chains ----
	logic [SW-1:0] sum_s3 [2];

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s3[0] <= SW'(sq[0]) + SW'(sq[1]);
			sum_s3[1] <= SW'(sq[2]) + SW'(sq[3]);
		end
	end

	logic [SW-1:0]  sn    [2][RW+1];
	logic [RW+1:0]  srem  [2][RW+1];
	logic [RW-1:0]  sroot [2][RW+1];

	generate
		for (genvar c = 0; c < 2; c++) begin : g_root
			assign sn[c][0]    = sum_s3[c];
			assign srem[c][0]  = '0;
			assign sroot[c][0] = '0;
			for (genvar i = 0; i < RW; i++) begin : g_cell
				rwep_sqrt_cell #(.RW(RW), .I(i)) u_cell (
					.clk    (clk),
					.en     (en),
					.n_i    (sn[c][i]),
					.rem_i  (srem[c][i]),
					.root_i (sroot[c][i]),
					.n_o    (sn[c][i+1]),
					.rem_o  (srem[c][i+1]),
					.root_o (sroot[c][i+1])
				);
			end
		end
	endgenerate

	// ---- scale by |ratio| and clip to the error range ----
	logic [PW-1:0] scaled [2];

	generate
		for (genvar c = 0; c < 2; c++) begin : g_scale
			rwep_mul #(.AW(RW), .BW(W)) u_scale (
				.clk (clk),
				.en  (en),
				.a   (sroot[c][RW]),
				.b   (post_q[RW+3].rp),
				.p   (scaled[c])
			);
		end
	endgenerate

	logic [PW-F-1:0] eshift [2];
	logic [1:0]      esat;
	logic [EW-1:0]   eclip  [2];

	always_comb begin
		for (int c = 0; c < 2; c++) begin
			eshift[c] = scaled[c][PW-1:F];
			esat[c]   = |eshift[c][PW-F-1:EW];
			eclip[c]  = esat[c] ? '1 : eshift[c][EW-1:0];
		end
	end

	// ---- output register ----
	post_t         post_end;
	logic [W-1:0]  x_q, ratio_q;
	logic [EW-1:0] eup_q, edn_q, xh_q, xl_q;
	logic          sat_q;

	assign post_end = post_q[PL-1];

	always_ff @(posedge clk) begin
		if (en) begin
			x_q     <= post_end.x;
			ratio_q <= post_end.ratio;
			eup_q   <= eclip[0];
			edn_q   <= eclip[1];
			xh_q    <= post_end.xh;
			xl_q    <= post_end.xl;
			sat_q   <= post_end.sat || (|esat);
		end
	end

	assign result.valid          = vld_q[NST-1];
	assign result.x_out          = x_q;
	assign result.ratio          = ratio_q;
	assign result.ratio_err_up   = eup_q;
	assign result.ratio_err_down = edn_q;
	assign result.xerr_high_out  = xh_q;
	assign result.xerr_low_out   = xl_q;
	assign result.saturated      = sat_q;
endmodule
`default_nettype wire

[rtl/core/rwep_chk.sv]
`default_nettype none
`include "ratio_with_error_propagation_macros.svh"
module rwep_chk (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready
);
	// a result once shown stays until taken
	`RWEP_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	// an empty output slot never blocks the input
	`RWEP_ASSERT_NOW(a_ready_when_empty, clk, arst_n, !out_valid, in_ready)
	// taking a result frees the input in the same cycle
	`RWEP_ASSERT_NOW(a_ready_on_take, clk, arst_n, out_valid && out_ready, in_ready)
	// reset empties the pipe
	`RWEP_ASSERT_ALWAYS(a_reset_empty, clk, !arst_n, !out_valid)

	logic unused_in_valid;
	assign unused_in_valid = in_valid;
endmodule

bind ratio_with_error_propagation rwep_chk u_rwep_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (point.valid),
	.in_ready  (point.ready),
	.out_valid (result.valid),
	.out_ready (result.ready)
);
`default_nettype wire

[tb/sv/ratio_with_error_propagation_checker.sv]
`timescale 1ns / 100ps
module ratio_with_error_propagation_checker
	import rwep_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	rwep_in_if.sink  point,
	rwep_out_if.sink result,
	output int   fail_count,
	output int   pending_count
);
	localparam int FB = DEF_FRAC_BITS;
	localparam int VW = DEF_VALUE_WIDTH;

	typedef struct packed {
		logic [VW-1:0] x_out;
		logic [VW-1:0] ratio;
		logic [VW-2:0] err_up;
		logic [VW-2:0] err_down;
		logic [VW-2:0] xerr_high;
		logic [VW-2:0] xerr_low;
		logic          saturated;
	} ratio_point_t;

	ratio_point_t ratio_fifo[$];

	// Floor of (a << FB) / d, clipped to limit; sets sat on clipping.
	function automatic logic [63:0] quot_clip(logic [63:0] a, logic [63:0] d,
		logic [63:0] limit, inout logic sat);
		logic [127:0] q;
		if (d == 0) begin
			sat = 1'b1;
			return limit;
		end
		q = ({64'd0, a} << FB) / {64'd0, d};
		if (q > {64'd0, limit}) begin
			sat = 1'b1;
			return limit;
		end
		return q[63:0];
	endfunction

	function automatic logic [63:0] root128(logic [127:0] n);
		logic [63:0]  res;
		logic [63:0]  cand;
		res = 0;
		for (int b = 62; b >= 0; b--) begin
			cand = res | (64'd1 << b);
			if ({64'd0, cand} * {64'd0, cand} <= n)
				res = cand;
		end
		return res;
	endfunction

	function automatic logic [VW-2:0] spread(logic [63:0] en, logic [63:0] nd,
		logic [63:0] ed, logic [63:0] dd, logic [63:0] rp, inout logic sat);
		logic [63:0]  ta;
		logic [63:0]  tb;
		logic [63:0]  s;
		logic [127:0] p;
		localparam logic [63:0] TMAX = (64'd1 << TERM_CAP_BITS) - 1;
		localparam logic [127:0] EMAX = (128'd1 << (VW - 1)) - 1;
		ta = quot_clip(en, nd, TMAX, sat);
		tb = quot_clip(ed, dd, TMAX, sat);
		s = root128({64'd0, ta} * {64'd0, ta} + {64'd0, tb} * {64'd0, tb});
		p = ({64'd0, s} * {64'd0, rp}) >> FB;
		if (p > EMAX) begin
			sat = 1'b1;
			return EMAX[VW-2:0];
		end
		return p[VW-2:0];
	endfunction

	function automatic ratio_point_t predict_ratio(logic [VW-1:0] xv, logic [VW-1:0] nv,
		logic [VW-1:0] dv, logic [VW-2:0] enu, logic [VW-2:0] end_, logic [VW-2:0] edu,
		logic [VW-2:0] edd, logic [VW-2:0] nxh, logic [VW-2:0] nxl, logic [VW-2:0] dxh,
		logic [VW-2:0] dxl);
		ratio_point_t r;
		logic         sat;
		logic [63:0]  nmag;
		logic [63:0]  dmag;
		logic [63:0]  qmag;
		logic [63:0]  rp;
		logic [63:0]  nd;
		logic [63:0]  dd;
		sat = 1'b0;
		nmag = nv[VW-1] ? 64'(-{1'b0, nv}) & ((64'd1 << VW) - 1) : 64'(nv);
		dmag = dv[VW-1] ? 64'(-{1'b0, dv}) & ((64'd1 << VW) - 1) : 64'(dv);
		qmag = 0;
		r.ratio = '0;
		if (!dv[VW-1] && dmag != 0) begin
			qmag = quot_clip(nmag, dmag,
				nv[VW-1] ? (64'd1 << (VW - 1)) : (64'd1 << (VW - 1)) - 1, sat);
			r.ratio = nv[VW-1] ? VW'(-qmag) : VW'(qmag);
		end
		rp = qmag != 0 ? qmag : 64'd1 << FB;
		nd = nmag != 0 ? nmag : 64'd1 << FB;
		dd = dmag != 0 ? dmag : 64'd1 << FB;
		r.x_out = xv;
		r.err_up = spread(64'(enu), nd, 64'(edd), dd, rp, sat);
		r.err_down = spread(64'(end_), nd, 64'(edu), dd, rp, sat);
		r.xerr_high = nxh > dxh ? nxh : dxh;
		r.xerr_low = nxl > dxl ? nxl : dxl;
		r.saturated = sat;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		ratio_point_t want;
		ratio_point_t got;
		if (!arst_n) begin
			fail_count <= 0;
			pending_count <= 0;
		end else begin
			if (point.valid && point.ready)
				ratio_fifo.push_back(predict_ratio(point.x_value, point.num_value,
					point.den_value, point.num_err_up, point.num_err_down, point.den_err_up,
					point.den_err_down, point.num_xerr_high, point.num_xerr_low,
					point.den_xerr_high, point.den_xerr_low));
			if (result.valid && result.ready) begin
				got = '{result.x_out, result.ratio, result.ratio_err_up, result.ratio_err_down,
					result.xerr_high_out, result.xerr_low_out, result.saturated};
				if (ratio_fifo.size() == 0) begin
					$display("%0t: unexpected result %h", $time, got);
					fail_count <= fail_count + 1;
				end else begin
					want = ratio_fifo.pop_front();
					if (got !== want) begin
						$display("%0t: mismatch expected x=%h r=%h eu=%h ed=%h xh=%h xl=%h s=%b",
							$time, want.x_out, want.ratio, want.err_up, want.err_down,
							want.xerr_high, want.xerr_low, want.saturated);
						$display("%0t:          actual   x=%h r=%h eu=%h ed=%h xh=%h xl=%h s=%b",
							$time, got.x_out, got.ratio, got.err_up, got.err_down,
							got.xerr_high, got.xerr_low, got.saturated);
						fail_count <= fail_count + 1;
					end
				end
			end
			pending_count <= ratio_fifo.size();
		end
	end
endmodule

[tb/sv/ratio_with_error_propagation_test.sv]
`timescale 1ns / 100ps
module ratio_with_error_propagation_test;
	import rwep_pkg::*;

	localparam int VW = DEF_VALUE_WIDTH;
	// pipe depth at the default widths
	localparam int PIPE_DEPTH = 104;

	logic clk = 1'b0;
	logic arst_n;
	int   fail_count;
	int   pending_count;
	int   send_idle_pct = 0;
	int   recv_stall_pct = 0;

	rwep_in_if  #(.W(VW)) point ();
	rwep_out_if #(.W(VW)) result ();

	ratio_with_error_propagation uut (
		.clk(clk), .arst_n(arst_n), .point(point.sink), .result(result.source)
	);

	ratio_with_error_propagation_checker checker_i (
		.clk(clk), .arst_n(arst_n), .point(point.sink), .result(result.sink),
		.fail_count(fail_count), .pending_count(pending_count)
	);

	always #5 clk = ~clk;

	// Receiver: stall at the rate of the current phase.
	always @(posedge clk)
		result.ready <= ($urandom_range(99) >= recv_stall_pct);

	// Value with a bias toward the edges of the signed range.
	function automatic logic [VW-1:0] pick_value();
		case ($urandom_range(7))
		0: return {1'b1, {(VW - 1){1'b0}}};
		1: return {1'b0, {(VW - 1){1'b1}}};
		2: return VW'($urandom_range(3)) << 16;
		3: return -(VW'($urandom_range(3)) << 16);
		4: return VW'($urandom_range(255));
		default: return VW'($urandom);
		endcase
	endfunction

	function automatic logic [VW-2:0] pick_err();
		case ($urandom_range(5))
		0: return '0;
		1: return '1;
		2: return (VW - 1)'($urandom_range(65535));
		default: return (VW - 1)'($urandom);
		endcase
	endfunction

	// Present one item and hold it until the block takes it.
	task automatic send_point(logic [VW-1:0] n, logic [VW-1:0] d, logic [VW-2:0] e);
		while ($urandom_range(99) < send_idle_pct) begin
			point.valid <= 1'b0;
			@(posedge clk);
		end
		point.valid         <= 1'b1;
		point.x_value       <= VW'($urandom);
		point.num_value     <= n;
		point.den_value     <= d;
		point.num_err_up    <= e;
		point.num_err_down  <= pick_err();
		point.den_err_up    <= pick_err();
		point.den_err_down  <= pick_err();
		point.num_xerr_high <= pick_err();
		point.num_xerr_low  <= pick_err();
		point.den_xerr_high <= pick_err();
		point.den_xerr_low  <= pick_err();
		@(posedge clk);
		while (!point.ready)
			@(posedge clk);
	endtask

	task automatic drain_pipe();
		point.valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
	endtask

	// Hard stop in case the pipe hangs.
	initial begin
		#5ms;
		$display("ratio_with_error_propagation regression: fail");
		$finish;
	end

	initial begin
		logic [VW-1:0] edge_vals[6];
		// assert reset at time zero so the pipe is empty before the first edge
		arst_n <= 1'b0;
		point.valid = 1'b0;
		point.x_value = '0;
		point.num_value = '0;
		point.den_value = '0;
		point.num_err_up = '0;
		point.num_err_down = '0;
		point.den_err_up = '0;
		point.den_err_down = '0;
		point.num_xerr_high = '0;
		point.num_xerr_low = '0;
		point.den_xerr_high = '0;
		point.den_xerr_low = '0;
		result.ready = 1'b0;
		edge_vals = '{{1'b1, {(VW - 1){1'b0}}}, {1'b0, {(VW - 1){1'b1}}}, '0,
			VW'(1) << 16, -(VW'(1) << 16), VW'(1)};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: edge-value numerators against extreme, zero and negative denominators.
		foreach (edge_vals[i])
			foreach (edge_vals[j])
				if ((i * 6 + j) % 3 != 2 || j == 2)
					send_point(edge_vals[i], edge_vals[j], (i + j) % 2 ? '1 : '0);
		// Wait for every result before the random part.
		drain_pipe();

		// Random: phases with no idling, sender idle, receiver stall, both.
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct  = (ph == 1) ? 59 : (ph == 3) ? 30 : 0;
			recv_stall_pct = (ph == 2) ? 59 : (ph == 3) ? 30 : 0;
			repeat (300)
				send_point(pick_value(), pick_value(), pick_err());
			if (ph == 1)
				drain_pipe();
		end
		point.valid <= 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		while (pending_count != 0)
			@(posedge clk);
		repeat (PIPE_DEPTH + 10) @(posedge clk);
		if (fail_count == 0)
			$display("ratio_with_error_propagation regression: pass");
		else
			$display("ratio_with_error_propagation regression: fail");
		$finish;
	end
endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/rwep_pkg.sv
rtl/core/rwep_in_if.sv
rtl/core/rwep_out_if.sv
rtl/core/rwep_div_cell.sv
rtl/core/rwep_sqrt_cell.sv
rtl/core/rwep_mul.sv
rtl/core/ratio_with_error_propagation.sv
rtl/core/rwep_chk.sv
tb/sv/ratio_with_error_propagation_checker.sv
tb/sv/ratio_with_error_propagation_test.sv
